/* rtl/firmware_image_marker_scanner_top_assert.svh */
// Assertion macros for the marker scanner checker.
`ifndef FIRMWARE_IMAGE_MARKER_SCANNER_TOP_ASSERT_SVH
`define FIRMWARE_IMAGE_MARKER_SCANNER_TOP_ASSERT_SVH

// Same-cycle implication.
`define FWMS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define FWMS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/fwms_pkg.sv */
package fwms_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned WORD_W   = 32;
   localparam int unsigned OFF_W    = 9;
   localparam int unsigned CSR_ADDR_W = 1;

   localparam logic [63:0] HEAD_MARK     = 64'h3631_3630_7365_656B;
   localparam logic [63:0] TAIL_MARK     = 64'h3631_3630_7761_7665;
   localparam logic [31:0] NV_START_MARK = 32'h4E56_5354;
   localparam logic [31:0] NV_END_MARK   = 32'h4E56_4544;
   localparam int unsigned MIN_IMAGE     = 16;
   localparam int unsigned NV_MARK_LEN   = 4;

   localparam logic [CSR_ADDR_W-1:0] CSR_CODE_ADDR = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_DATA_ADDR = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_SHORT  = 2'd1,
      STATUS_FORMAT = 2'd2
   } status_type;

endpackage

/* rtl/fwms_if.sv */
interface fwms_req_if import fwms_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] image_byte;
   logic              is_last;

   modport source (output valid, output image_byte, output is_last, input ready);
   modport sink   (input valid, input image_byte, input is_last, output ready);
endinterface

interface fwms_rsp_if import fwms_pkg::*; ();
   logic              valid;
   logic              ready;
   status_type        status;
   logic [OFF_W-1:0]  hdr_offset;
   logic [OFF_W-1:0]  tail_offset;
   logic              nv_found;
   logic [OFF_W-1:0]  nv_base;
   logic [OFF_W-1:0]  nv_size;
   logic [WORD_W-1:0] code_address;
   logic [WORD_W-1:0] data_address;

   modport source (output valid, output status, output hdr_offset,
                   output tail_offset, output nv_found, output nv_base,
                   output nv_size, output code_address, output data_address,
                   input ready);
   modport sink   (input valid, input status, input hdr_offset,
                   input tail_offset, input nv_found, input nv_base,
                   input nv_size, input code_address, input data_address,
                   output ready);
endinterface

interface fwms_csr_if import fwms_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] addr;
   logic [WORD_W-1:0]     data;

   modport source (output valid, output addr, output data, input ready);
   modport sink   (input valid, input addr, input data, output ready);
endinterface

/* rtl/firmware_image_marker_scanner_top.sv */
// Firmware image marker scanner. Takes one image byte per beat, in order from
// offset zero, and scans the first WINDOW_BYTES bytes for the header, tail and
// NV region markers at 4-byte-aligned offsets. On the beat flagged is_last it
// returns one result beat (status, marker offsets, NV region, load addresses)
// and clears itself for the next image. A byte is taken every cycle unless
// stalled; the result appears in the cycle after the last byte is accepted,
// held in a single output register; req ready drops only while that register
// is full and not being taken. The load-address registers are written through
// the csr channel (index 0 code address, index 1 data address), always ready.
module firmware_image_marker_scanner_top import fwms_pkg::*; #(
   parameter int unsigned WINDOW_BYTES = 512
) (
   input  logic       clock,
   input  logic       reset,
   fwms_req_if.sink   req_chan,
   fwms_rsp_if.source rsp_chan,
   fwms_csr_if.sink   csr_chan
);

   localparam int unsigned POS_W = $clog2(WINDOW_BYTES);
   localparam int unsigned CNT_W = $clog2(WINDOW_BYTES + 1);
   localparam int unsigned EXT_W = POS_W + 2;

   function automatic logic [OFF_W-1:0] to_off(input logic [EXT_W-1:0] v);
      logic [EXT_W+OFF_W-1:0] w;
      w = {{OFF_W{1'b0}}, v};
      return w[OFF_W-1:0];
   endfunction

   logic [WORD_W-1:0] exp_code_ff;
   logic [WORD_W-1:0] exp_data_ff;

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [63:0]       recent_ff, recent_in;
   logic              hdr_seen_ff, hdr_seen_in;
   logic [POS_W-1:0]  hdr_pos_ff, hdr_pos_in;
   logic              tail_seen_ff, tail_seen_in;
   logic [POS_W-1:0]  tail_pos_ff, tail_pos_in;
   logic              nvs_seen_ff, nvs_seen_in;
   logic [POS_W-1:0]  nvs_pos_ff, nvs_pos_in;
   logic              nve_seen_ff, nve_seen_in;
   logic [POS_W-1:0]  nve_pos_ff, nve_pos_in;
   logic [WORD_W-1:0] code_ff, code_in;
   logic [WORD_W-1:0] data_ff, data_in;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        status_ff, status_in;
   logic [OFF_W-1:0]  hdr_off_ff, hdr_off_in;
   logic [OFF_W-1:0]  tail_off_ff, tail_off_in;
   logic              nv_found_ff, nv_found_in;
   logic [OFF_W-1:0]  nv_off_ff, nv_off_in;
   logic [OFF_W-1:0]  nv_cap_ff, nv_cap_in;
   logic [WORD_W-1:0] code_out_ff, code_out_in;
   logic [WORD_W-1:0] data_out_ff, data_out_in;

   logic              accept;
   logic              accept_last;
   logic [POS_W-1:0]  pos;
   logic [EXT_W-1:0]  pos_ext;
   logic [EXT_W-1:0]  hdr_ext_ff;
   logic [EXT_W-1:0]  hdr_ext, tail_ext, nvs_ext, nve_ext, nvs_end_ext, len_ext;
   logic              nv_ok;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign accept_last    = accept && req_chan.is_last;
   assign csr_chan.ready = 1'b1;

   assign pos        = cnt_ff[POS_W-1:0];
   assign pos_ext    = EXT_W'(pos);
   assign hdr_ext_ff = EXT_W'(hdr_pos_ff);

   // Per-byte scan
   always_comb begin
      cnt_in       = cnt_ff;
      recent_in    = recent_ff;
      hdr_seen_in  = hdr_seen_ff;
      hdr_pos_in   = hdr_pos_ff;
      tail_seen_in = tail_seen_ff;
      tail_pos_in  = tail_pos_ff;
      nvs_seen_in  = nvs_seen_ff;
      nvs_pos_in   = nvs_pos_ff;
      nve_seen_in  = nve_seen_ff;
      nve_pos_in   = nve_pos_ff;
      code_in      = code_ff;
      data_in      = data_ff;
      if (cnt_ff < CNT_W'(WINDOW_BYTES)) begin
         cnt_in    = cnt_ff + 1'b1;
         recent_in = {req_chan.image_byte, recent_ff[63:8]};
         if (pos[1:0] == 2'b11) begin
            if (hdr_seen_ff && pos_ext == hdr_ext_ff + EXT_W'(11)) begin
               code_in = recent_in[63:32];
            end
            if (hdr_seen_ff && pos_ext == hdr_ext_ff + EXT_W'(15)) begin
               data_in = recent_in[63:32];
            end
            if (pos[POS_W-1:2] != '0) begin
               if (!hdr_seen_ff && recent_in == HEAD_MARK) begin
                  hdr_seen_in = 1'b1;
                  hdr_pos_in  = pos - POS_W'(7);
               end
               if (!tail_seen_ff && recent_in == TAIL_MARK) begin
                  tail_seen_in = 1'b1;
                  tail_pos_in  = pos - POS_W'(7);
               end
            end
            if (!nvs_seen_ff && recent_in[63:32] == NV_START_MARK) begin
               nvs_seen_in = 1'b1;
               nvs_pos_in  = pos - POS_W'(3);
            end
            if (!nve_seen_ff && recent_in[63:32] == NV_END_MARK) begin
               nve_seen_in = 1'b1;
               nve_pos_in  = pos - POS_W'(3);
            end
         end
      end
   end

   // Result from the state after this byte
   assign hdr_ext     = EXT_W'(hdr_pos_in);
   assign tail_ext    = EXT_W'(tail_pos_in);
   assign nvs_ext     = EXT_W'(nvs_pos_in);
   assign nve_ext     = EXT_W'(nve_pos_in);
   assign nvs_end_ext = nvs_ext + EXT_W'(NV_MARK_LEN);
   assign len_ext     = EXT_W'(cnt_in);

   assign nv_ok = nvs_seen_in && nve_seen_in &&
                  nvs_end_ext <= hdr_ext &&
                  nve_ext + EXT_W'(NV_MARK_LEN) <= hdr_ext &&
                  nve_ext >= nvs_end_ext;

   always_comb begin
      status_in   = STATUS_OK;
      hdr_off_in  = '0;
      tail_off_in = '0;
      nv_found_in = 1'b0;
      nv_off_in   = '0;
      nv_cap_in   = '0;
      code_out_in = '0;
      data_out_in = '0;
      priority if (len_ext < EXT_W'(MIN_IMAGE)) begin
         status_in = STATUS_SHORT;
      end else if (!hdr_seen_in || !tail_seen_in ||
                   hdr_ext + EXT_W'(MIN_IMAGE) > len_ext ||
                   tail_ext <= hdr_ext + EXT_W'(MIN_IMAGE) ||
                   code_in != exp_code_ff || data_in != exp_data_ff) begin
         status_in = STATUS_FORMAT;
      end else begin
         hdr_off_in  = to_off(hdr_ext);
         tail_off_in = to_off(tail_ext);
         code_out_in = code_in;
         data_out_in = data_in;
         if (nv_ok) begin
            nv_found_in = 1'b1;
            nv_off_in   = to_off(nvs_end_ext);
            nv_cap_in   = to_off(nve_ext - nvs_end_ext);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept_last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_code_ff <= '0;
         exp_data_ff <= '0;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.addr)
            CSR_CODE_ADDR: exp_code_ff <= csr_chan.data;
            CSR_DATA_ADDR: exp_data_ff <= csr_chan.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || accept_last) begin
         cnt_ff       <= '0;
         recent_ff    <= '0;
         hdr_seen_ff  <= 1'b0;
         hdr_pos_ff   <= '0;
         tail_seen_ff <= 1'b0;
         tail_pos_ff  <= '0;
         nvs_seen_ff  <= 1'b0;
         nvs_pos_ff   <= '0;
         nve_seen_ff  <= 1'b0;
         nve_pos_ff   <= '0;
         code_ff      <= '0;
         data_ff      <= '0;
      end else if (accept) begin
         cnt_ff       <= cnt_in;
         recent_ff    <= recent_in;
         hdr_seen_ff  <= hdr_seen_in;
         hdr_pos_ff   <= hdr_pos_in;
         tail_seen_ff <= tail_seen_in;
         tail_pos_ff  <= tail_pos_in;
         nvs_seen_ff  <= nvs_seen_in;
         nvs_pos_ff   <= nvs_pos_in;
         nve_seen_ff  <= nve_seen_in;
         nve_pos_ff   <= nve_pos_in;
         code_ff      <= code_in;
         data_ff      <= data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_last) begin
         status_ff   <= status_in;
         hdr_off_ff  <= hdr_off_in;
         tail_off_ff <= tail_off_in;
         nv_found_ff <= nv_found_in;
         nv_off_ff   <= nv_off_in;
         nv_cap_ff   <= nv_cap_in;
         code_out_ff <= code_out_in;
         data_out_ff <= data_out_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = status_ff;
   assign rsp_chan.hdr_offset   = hdr_off_ff;
   assign rsp_chan.tail_offset  = tail_off_ff;
   assign rsp_chan.nv_found     = nv_found_ff;
   assign rsp_chan.nv_base      = nv_off_ff;
   assign rsp_chan.nv_size      = nv_cap_ff;
   assign rsp_chan.code_address = code_out_ff;
   assign rsp_chan.data_address = data_out_ff;

endmodule

/* rtl/fwms_checker.sv */
`include "firmware_image_marker_scanner_top_assert.svh"

module fwms_checker import fwms_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input status_type        status,
   input logic [OFF_W-1:0]  hdr_offset,
   input logic [OFF_W-1:0]  tail_offset,
   input logic              nv_found,
   input logic [OFF_W-1:0]  nv_base,
   input logic [OFF_W-1:0]  nv_size,
   input logic [WORD_W-1:0] code_address,
   input logic [WORD_W-1:0] data_address
);

   logic fail_fields_zero;
   logic no_nv_zero;

   assign fail_fields_zero = hdr_offset == '0 && tail_offset == '0 &&
                             !nv_found && nv_base == '0 && nv_size == '0 &&
                             code_address == '0 && data_address == '0;
   assign no_nv_zero = nv_base == '0 && nv_size == '0;

   `FWMS_ASSERT_IMPLY(a_fail_zero, clock, reset, rsp_valid && status != STATUS_OK, fail_fields_zero, "failed image reports nonzero fields")
   `FWMS_ASSERT_IMPLY(a_no_nv_zero, clock, reset, rsp_valid && !nv_found, no_nv_zero, "NV fields set without NV region")
   `FWMS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(code_address), "stalled result beat changed")

endmodule

bind firmware_image_marker_scanner_top fwms_checker u_fwms_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .status       (rsp_chan.status),
   .hdr_offset   (rsp_chan.hdr_offset),
   .tail_offset  (rsp_chan.tail_offset),
   .nv_found     (rsp_chan.nv_found),
   .nv_base      (rsp_chan.nv_base),
   .nv_size      (rsp_chan.nv_size),
   .code_address (rsp_chan.code_address),
   .data_address (rsp_chan.data_address)
);

/* tb/tb_firmware_image_marker_scanner_top.sv */
module tb_firmware_image_marker_scanner_top import fwms_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned WINDOW      = 512;
   localparam int unsigned LIMIT       = 200000;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned PHASE_BYTES = 16;
   localparam int          NO_MARK     = -1;

   typedef enum int unsigned {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_kind_type;

   typedef struct packed {
      status_type        status;
      logic [OFF_W-1:0]  hdr_offset;
      logic [OFF_W-1:0]  tail_offset;
      logic              nv_found;
      logic [OFF_W-1:0]  nv_base;
      logic [OFF_W-1:0]  nv_size;
      logic [WORD_W-1:0] code_address;
      logic [WORD_W-1:0] data_address;
   } scan_result_type;

   typedef struct {
      int unsigned       len;
      int                hdr;
      int                tail;
      int                nv_start;
      int                nv_end;
      int                extra_hdr;
      logic [WORD_W-1:0] code;
      logic [WORD_W-1:0] data;
      fill_kind_type     fill;
      bit                typed;
      status_type        want;
   } image_row_type;

   // registers stay at reset value (zero) for all rows
   image_row_type directed_rows [18] = '{
      '{1,   NO_MARK, NO_MARK, NO_MARK, NO_MARK, NO_MARK, 0, 0, FILL_RANDOM, 1, STATUS_SHORT},
      '{15,  0,       NO_MARK, NO_MARK, NO_MARK, NO_MARK, 0, 0, FILL_RANDOM, 1, STATUS_SHORT},
      '{16,  NO_MARK, NO_MARK, NO_MARK, NO_MARK, NO_MARK, 0, 0, FILL_ZERO,   1, STATUS_FORMAT},
      '{16,  0,       NO_MARK, NO_MARK, NO_MARK, NO_MARK, 0, 0, FILL_ZERO,   1, STATUS_FORMAT},
      '{24,  0,       16,      NO_MARK, NO_MARK, NO_MARK, 0, 0, FILL_ZERO,   1, STATUS_FORMAT},
      '{28,  0,       20,      NO_MARK, NO_MARK, NO_MARK, 0, 0, FILL_RANDOM, 0, STATUS_OK},
      '{28,  0,       20,      NO_MARK, NO_MARK, NO_MARK, 1, 0, FILL_ZERO,   1, STATUS_FORMAT},
      '{28,  0,       20,      NO_MARK, NO_MARK, NO_MARK, 0, 32'h8000_0000, FILL_ZERO, 1,
        STATUS_FORMAT},
      '{44,  16,      36,      0,       12,      NO_MARK, 0, 0, FILL_RANDOM, 0, STATUS_OK},
      '{44,  16,      36,      8,       0,       NO_MARK, 0, 0, FILL_RANDOM, 0, STATUS_OK},
      '{36,  8,       28,      0,       4,       NO_MARK, 0, 0, FILL_RANDOM, 0, STATUS_OK},
      '{40,  8,       32,      0,       28,      NO_MARK, 0, 0, FILL_RANDOM, 0, STATUS_OK},
      '{513, 484,     504,     NO_MARK, NO_MARK, NO_MARK, 0, 0, FILL_RANDOM, 0, STATUS_OK},
      '{44,  0,       20,      NO_MARK, NO_MARK, 28,      0, 0, FILL_RANDOM, 0, STATUS_OK},
      '{28,  2,       20,      NO_MARK, NO_MARK, NO_MARK, 0, 0, FILL_ZERO,   1, STATUS_FORMAT},
      '{32,  24,      0,       NO_MARK, NO_MARK, NO_MARK, 0, 0, FILL_ZERO,   1, STATUS_FORMAT},
      '{20,  NO_MARK, NO_MARK, NO_MARK, NO_MARK, NO_MARK, 0, 0, FILL_ONES,   1, STATUS_FORMAT},
      '{20,  NO_MARK, NO_MARK, 4,       12,      NO_MARK, 0, 0, FILL_RANDOM, 0, STATUS_OK}
   };

   logic clock;
   logic reset;

   fwms_req_if req_bus ();
   fwms_rsp_if rsp_bus ();
   fwms_csr_if csr_bus ();

   firmware_image_marker_scanner_top #(.WINDOW_BYTES(WINDOW)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // scanner model state
   logic [WORD_W-1:0] want_code_addr;
   logic [WORD_W-1:0] want_data_addr;
   int unsigned       seen_count;
   logic [63:0]       last_eight;
   logic              hdr_hit, tail_hit, nvs_hit, nve_hit;
   int unsigned       hdr_at, tail_at, nvs_at, nve_at;
   logic [WORD_W-1:0] code_seen, data_seen;

   scan_result_type   pending_results [$];
   logic [7:0]        image_buf [$];

   bit          no_gaps;
   bit          hold_rsp;
   int unsigned err_count, cycle_count, bytes_sent, images_sent;
   int unsigned n_results, n_ok, n_short, n_format, n_nv;

   function automatic void restart_scan();
      seen_count = 0;
      last_eight = '0;
      hdr_hit    = 1'b0;
      tail_hit   = 1'b0;
      nvs_hit    = 1'b0;
      nve_hit    = 1'b0;
      hdr_at     = 0;
      tail_at    = 0;
      nvs_at     = 0;
      nve_at     = 0;
      code_seen  = '0;
      data_seen  = '0;
   endfunction

   function automatic bit predict_scan(input logic [7:0] b, input logic last,
                                       output scan_result_type r);
      int unsigned       p;
      logic [WORD_W-1:0] low;
      r = '0;
      if (seen_count < WINDOW) begin
         p = seen_count;
         last_eight = {b, last_eight[63:8]};
         if (p % 4 == 3) begin
            low = last_eight[63:32];
            if (hdr_hit && p == hdr_at + 11) code_seen = low;
            if (hdr_hit && p == hdr_at + 15) data_seen = low;
            if (p >= 7) begin
               if (!hdr_hit && last_eight == HEAD_MARK) begin
                  hdr_hit = 1'b1;
                  hdr_at  = p - 7;
               end
               if (!tail_hit && last_eight == TAIL_MARK) begin
                  tail_hit = 1'b1;
                  tail_at  = p - 7;
               end
            end
            if (!nvs_hit && low == NV_START_MARK) begin
               nvs_hit = 1'b1;
               nvs_at  = p - 3;
            end
            if (!nve_hit && low == NV_END_MARK) begin
               nve_hit = 1'b1;
               nve_at  = p - 3;
            end
         end
         seen_count = seen_count + 1;
      end
      if (!last) return 1'b0;
      if (seen_count < MIN_IMAGE) begin
         r.status = STATUS_SHORT;
      end else if (!hdr_hit || !tail_hit || hdr_at + MIN_IMAGE > seen_count ||
                   tail_at <= hdr_at + MIN_IMAGE ||
                   code_seen != want_code_addr || data_seen != want_data_addr) begin
         r.status = STATUS_FORMAT;
      end else begin
         r.status       = STATUS_OK;
         r.hdr_offset   = OFF_W'(hdr_at);
         r.tail_offset  = OFF_W'(tail_at);
         r.code_address = code_seen;
         r.data_address = data_seen;
         if (nvs_hit && nve_hit && nvs_at + NV_MARK_LEN <= hdr_at &&
             nve_at + NV_MARK_LEN <= hdr_at && nve_at >= nvs_at + NV_MARK_LEN) begin
            r.nv_found = 1'b1;
            r.nv_base  = OFF_W'(nvs_at + NV_MARK_LEN);
            r.nv_size  = OFF_W'(nve_at - (nvs_at + NV_MARK_LEN));
         end
      end
      restart_scan();
      return 1'b1;
   endfunction

   function automatic void place_word(input int at, input logic [31:0] w);
      for (int k = 0; k < 4; k++) begin
         if (at >= 0 && at + k < image_buf.size()) image_buf[at + k] = w[8*k +: 8];
      end
   endfunction

   function automatic void place_header(input int at, input logic [WORD_W-1:0] code,
                                        input logic [WORD_W-1:0] data);
      if (at < 0) return;
      place_word(at, HEAD_MARK[31:0]);
      place_word(at + 4, HEAD_MARK[63:32]);
      place_word(at + 8, code);
      place_word(at + 12, data);
   endfunction

   function automatic void build_image(input int unsigned len, input int hdr, input int tl,
                                       input int ns, input int ne, input int hdr2,
                                       input logic [WORD_W-1:0] code,
                                       input logic [WORD_W-1:0] data,
                                       input fill_kind_type fill);
      image_buf.delete();
      for (int i = 0; i < len; i++) begin
         case (fill)
            FILL_ZERO: image_buf.push_back(8'h00);
            FILL_ONES: image_buf.push_back(8'hFF);
            default:   image_buf.push_back(8'($urandom_range(0, 255)));
         endcase
      end
      if (ns >= 0) place_word(ns, NV_START_MARK);
      if (ne >= 0) place_word(ne, NV_END_MARK);
      place_header(hdr, code, data);
      place_header(hdr2, code, data);
      if (tl >= 0) begin
         place_word(tl, TAIL_MARK[31:0]);
         place_word(tl + 4, TAIL_MARK[63:32]);
      end
   endfunction

   task automatic random_image(input bit tiny);
      int unsigned       len, w, pick;
      int                h, t, ns, ne;
      logic [WORD_W-1:0] c, d;
      pick = $urandom_range(0, 99);
      if (tiny) len = $urandom_range(1, 15);
      else if (pick < 8) len = $urandom_range(1, 15);
      else len = $urandom_range(16, 40);
      w  = (len < WINDOW) ? len : WINDOW;
      h  = NO_MARK;
      t  = NO_MARK;
      ns = NO_MARK;
      ne = NO_MARK;
      c  = want_code_addr;
      d  = want_data_addr;
      if ($urandom_range(0, 9) == 0) c = c ^ (32'd1 << $urandom_range(0, 31));
      if ($urandom_range(0, 9) == 0) d = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 75 && w >= 28) begin
         h = 4 * $urandom_range(0, (w - 28) / 4);
         t = 4 * $urandom_range((h + 20) / 4, (w - 8) / 4);
         if (h >= 8 && $urandom_range(0, 2) != 0) begin
            ns = 4 * $urandom_range(0, (h - 8) / 4);
            ne = 4 * $urandom_range((ns + 4) / 4, (h - 4) / 4);
         end
         if ($urandom_range(0, 9) == 0) h = h + $urandom_range(1, 3);
      end else if (pick < 90) begin
         if ($urandom_range(0, 1)) h = 4 * $urandom_range(0, (len - 1) / 4);
         if ($urandom_range(0, 1)) t = 4 * $urandom_range(0, (len - 1) / 4);
         if ($urandom_range(0, 1)) ns = $urandom_range(0, len - 1);
         if ($urandom_range(0, 1)) ne = 4 * $urandom_range(0, (len - 1) / 4);
      end
      build_image(len, h, t, ns, ne, NO_MARK, c, d, FILL_RANDOM);
   endtask

   task automatic send_beat(input logic [7:0] b, input logic last, input bit typed,
                            input scan_result_type fixed);
      int unsigned     gap;
      scan_result_type r;
      gap = no_gaps ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.image_byte <= b;
      req_bus.is_last    <= last;
      do @(posedge clock); while (!req_bus.ready);
      bytes_sent++;
      if (predict_scan(b, last, r)) pending_results.push_back(typed ? fixed : r);
   endtask

   task automatic send_image(input bit typed, input status_type want);
      scan_result_type fixed;
      fixed        = '0;
      fixed.status = want;
      foreach (image_buf[i]) send_beat(image_buf[i], i == image_buf.size() - 1, typed, fixed);
      images_sent++;
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_addresses(input logic [WORD_W-1:0] code, input logic [WORD_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.addr  <= CSR_CODE_ADDR;
      csr_bus.data  <= code;
      do @(posedge clock); while (!csr_bus.ready);
      want_code_addr = code;
      csr_bus.addr <= CSR_DATA_ADDR;
      csr_bus.data <= data;
      do @(posedge clock); while (!csr_bus.ready);
      want_data_addr = data;
      csr_bus.valid <= 1'b0;
   endtask

   task automatic run_phase(input logic [WORD_W-1:0] code, input logic [WORD_W-1:0] data,
                            input bit back_to_back);
      int unsigned start;
      settle();
      set_addresses(code, data);
      no_gaps = back_to_back;
      start   = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES) begin
         random_image(1'b0);
         send_image(1'b0, STATUS_OK);
      end
      settle();
      no_gaps = 1'b0;
   endtask

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
         err_count++;
      end
   endfunction

   always @(posedge clock) begin
      scan_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         n_results++;
         case (rsp_bus.status)
            STATUS_OK:     n_ok++;
            STATUS_SHORT:  n_short++;
            STATUS_FORMAT: n_format++;
            default: ;
         endcase
         if (rsp_bus.nv_found === 1'b1) n_nv++;
         if (pending_results.size() == 0) begin
            $error("result beat with no result pending");
            err_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_bus.status));
            check_field("hdr_offset", 32'(want.hdr_offset), 32'(rsp_bus.hdr_offset));
            check_field("tail_offset", 32'(want.tail_offset), 32'(rsp_bus.tail_offset));
            check_field("nv_found", 32'(want.nv_found), 32'(rsp_bus.nv_found));
            check_field("nv_base", 32'(want.nv_base), 32'(rsp_bus.nv_base));
            check_field("nv_size", 32'(want.nv_size), 32'(rsp_bus.nv_size));
            check_field("code_address", want.code_address, rsp_bus.code_address);
            check_field("data_address", want.data_address, rsp_bus.data_address);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      int unsigned stall;
      rsp_bus.ready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end
         stall = no_gaps ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   initial begin
      image_row_type row;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.image_byte = '0;
      req_bus.is_last    = 1'b0;
      csr_bus.valid      = 1'b0;
      csr_bus.addr       = CSR_CODE_ADDR;
      csr_bus.data       = '0;
      no_gaps            = 1'b0;
      hold_rsp           = 1'b0;
      want_code_addr     = '0;
      want_data_addr     = '0;
      restart_scan();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         build_image(row.len, row.hdr, row.tail, row.nv_start, row.nv_end, row.extra_hdr,
                     row.code, row.data, row.fill);
         send_image(row.typed, row.want);
      end

      run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      run_phase($urandom, $urandom, 1'b1);
      run_phase(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
      run_phase(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
      run_phase($urandom, $urandom, 1'b0);

      // result side held off while tiny images keep coming: input must back up
      settle();
      set_addresses($urandom, $urandom);
      no_gaps  = 1'b1;
      hold_rsp = 1'b1;
      repeat (6) begin
         random_image(1'b1);
         send_image(1'b0, STATUS_OK);
      end
      no_gaps = 1'b0;
      settle();
      repeat (8) @(posedge clock);

      $display("Scanned %0d images (%0d bytes) under 7 address settings incl. all-zero/all-one",
               images_sent, bytes_sent);
      $display("Results: %0d checked, %0d valid, %0d short, %0d format error, %0d with NV region",
               n_results, n_ok, n_short, n_format, n_nv);
      if (err_count == 0 && pending_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* firmware_image_marker_scanner_top.f */
+incdir+rtl
rtl/fwms_pkg.sv
rtl/fwms_if.sv
rtl/firmware_image_marker_scanner_top.sv
rtl/fwms_checker.sv
tb/tb_firmware_image_marker_scanner_top.sv
